// ----- sv/pvsc_pkg.sv -----
// Shared types, character codes and helper functions of the version string comparator.
package pvsc_pkg;

    // Command codes of an input beat.
    localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
    localparam logic [1:0] CMD_COMPARE       = 2'd2;
    localparam logic [1:0] CMD_UNUSED        = 2'd3;

    // Result codes.
    typedef logic signed [1:0] t_order;
    localparam t_order ORD_OLDER = 2'sb11;
    localparam t_order ORD_SAME  = 2'sb00;
    localparam t_order ORD_NEWER = 2'sb01;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOWR   = 8'h72;

    // Part classes, listed in their tie-break order.
    typedef enum logic [2:0] {
        PART_DOT,
        PART_LETTER,
        PART_SUFFIX,
        PART_HASH,
        PART_REV,
        PART_END,
        PART_BAD
    } t_part;

    // Character run being scanned.
    typedef enum logic [1:0] {
        SCAN_LOWER,
        SCAN_DIGIT,
        SCAN_HEX
    } t_scan;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FUZZY,
        ST_PART,
        ST_LEAD,
        ST_BODY,
        ST_REVDIG,
        ST_SCAN,
        ST_EVAL,
        ST_SAME,
        ST_DIFF,
        ST_ZERO,
        ST_ZERO_CHK,
        ST_NUM,
        ST_LEX_START,
        ST_LEX,
        ST_LEN
    } t_state;

    // Suffix words, right aligned, lowest rank first.
    localparam int WORD_COUNT = 9;
    localparam int WORD_MAX   = 5;
    localparam logic [2:0] WLEN_SAT = 3'd6;
    localparam logic [3:0] RANK_RELEASE_LAST = 4'd4;
    localparam logic [8*WORD_MAX-1:0] WORD_TEXT [WORD_COUNT] = '{
        "alpha", {8'h00, "beta"}, {16'h0000, "pre"}, {24'h000000, "rc"},
        {16'h0000, "cvs"}, {16'h0000, "svn"}, {16'h0000, "git"},
        {24'h000000, "hg"}, {32'h00000000, "p"}
    };
    localparam logic [2:0] WORD_LEN [WORD_COUNT] = '{
        3'd5, 3'd4, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd2, 3'd1
    };

    // Control from the sequencer to the text store.
    typedef struct packed {
        logic wr_first;
        logic wr_second;
        logic clear;
    } t_dp_cmd;

    // Status from the text store to the sequencer.
    typedef struct packed {
        logic [7:0] rd_first;
        logic [7:0] rd_second;
        logic       overflow;
    } t_dp_sts;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return c inside {[8'h61:8'h7A]};
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h61:8'h66]};
    endfunction

    // Class announced by a leading separator character.
    function automatic t_part lead_class(input logic [7:0] c);
        t_part k;
        case (c)
            CH_DOT:   k = PART_DOT;
            CH_UNDER: k = PART_SUFFIX;
            CH_DASH:  k = PART_REV;
            CH_TILDE: k = PART_HASH;
            default:  k = PART_BAD;
        endcase
        return k;
    endfunction

    // Rank 1..9 of a suffix word, 0 when the word is not known.
    function automatic logic [3:0] word_rank(input logic [8*WORD_MAX-1:0] text,
                                             input logic [2:0] len);
        logic [3:0] rank;
        rank = 4'd0;
        for (int k = 0; k < WORD_COUNT; k++) begin
            if (len == WORD_LEN[k] && text == WORD_TEXT[k]) begin
                rank = 4'(k + 1);
            end
        end
        return rank;
    endfunction

endpackage

// ----- sv/pvsc_if.sv -----
// Handshake channels for input beats and result beats.
interface pvsc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] byte_value;
    modport source (output valid, output command, output byte_value, input ready);
    modport sink (input valid, input command, input byte_value, output ready);
endinterface

interface pvsc_out_if;
    logic              valid;
    logic              ready;
    logic signed [1:0] order;
    logic              overflow;
    modport source (output valid, output order, output overflow, input ready);
    modport sink (input valid, input order, input overflow, output ready);
endinterface

// ----- sv/package_version_string_compare_unit.sv -----
// Append beats return no result beat.
// A compare beat walks both buffers part by part, one byte at a time, and compares
// equal text and byte-wise text a byte pair at a time; each text buffer has a single
// read port.
// One item is in work at a time; a finished result waits in an output register.
// Synchronous active-low reset empties both buffers and clears the overflow flag.
module package_version_string_compare_unit #(
    parameter int MAX_LEN = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    pvsc_in_if.sink    i_in,
    pvsc_out_if.source o_out
);
    localparam int LenW = $clog2(MAX_LEN + 1);
    localparam int AW   = $clog2(MAX_LEN);

    pvsc_pkg::t_dp_cmd w_dp_cmd;
    pvsc_pkg::t_dp_sts w_dp_sts;
    logic [LenW-1:0]   w_len_first, w_len_second;
    logic [AW-1:0]     w_raddr_first, w_raddr_second;

    pvsc_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .i_in_command   (i_in.command),
        .o_in_ready     (i_in.ready),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_order        (o_out.order),
        .o_overflow     (o_out.overflow),
        .o_dp_cmd       (w_dp_cmd),
        .i_dp_sts       (w_dp_sts),
        .i_len_first    (w_len_first),
        .i_len_second   (w_len_second),
        .o_raddr_first  (w_raddr_first),
        .o_raddr_second (w_raddr_second)
    );

    pvsc_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_dp_cmd),
        .i_byte         (i_in.byte_value),
        .i_raddr_first  (w_raddr_first),
        .i_raddr_second (w_raddr_second),
        .o_sts          (w_dp_sts),
        .o_len_first    (w_len_first),
        .o_len_second   (w_len_second)
    );

    // A new result beat always comes with both buffers emptied.
    a_result_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> (w_len_first == '0 && w_len_second == '0 && !w_dp_sts.overflow))
        else $error("buffers not cleared with result");

    // An accepted append to a first buffer with room grows it by one byte.
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.command == pvsc_pkg::CMD_APPEND_FIRST
         && w_len_first != LenW'(MAX_LEN))
        |=> (w_len_first == LenW'($past(w_len_first) + 1'b1)))
        else $error("append did not grow first buffer");

    // An append to a full second buffer raises the overflow flag.
    a_full_overflows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.command == pvsc_pkg::CMD_APPEND_SECOND
         && w_len_second == LenW'(MAX_LEN))
        |=> w_dp_sts.overflow)
        else $error("dropped byte did not set overflow");
endmodule

// ----- sv/pvsc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module pvsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/pvsc_datapath.sv -----
// Text store: both string buffers, their lengths and the overflow flag.
module pvsc_datapath #(
    parameter int MAX_LEN = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pvsc_pkg::t_dp_cmd              i_cmd,
    input  logic [7:0]                     i_byte,
    input  logic [$clog2(MAX_LEN)-1:0]     i_raddr_first,
    input  logic [$clog2(MAX_LEN)-1:0]     i_raddr_second,
    output pvsc_pkg::t_dp_sts              o_sts,
    output logic [$clog2(MAX_LEN+1)-1:0]   o_len_first,
    output logic [$clog2(MAX_LEN+1)-1:0]   o_len_second
);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam logic [LW-1:0] FULL = LW'(MAX_LEN);

    logic [LW-1:0] r_len_first, r_len_second;
    logic          r_overflow;
    logic          we_first, we_second;
    logic [7:0]    rd_first, rd_second;

    assign we_first  = i_cmd.wr_first && (r_len_first != FULL);
    assign we_second = i_cmd.wr_second && (r_len_second != FULL);

    // Lengths and overflow; a compare clears them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_len_first  <= '0;
            r_len_second <= '0;
            r_overflow   <= 1'b0;
        end else begin
            if (we_first) begin
                r_len_first <= r_len_first + LW'(1);
            end
            if (we_second) begin
                r_len_second <= r_len_second + LW'(1);
            end
            if ((i_cmd.wr_first && !we_first) || (i_cmd.wr_second && !we_second)) begin
                r_overflow <= 1'b1;
            end
        end
    end

    pvsc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first_text (
        .i_clk   (i_clk),
        .i_we    (we_first),
        .i_waddr (r_len_first[AW-1:0]),
        .i_wdata (i_byte),
        .i_raddr (i_raddr_first),
        .o_rdata (rd_first)
    );

    pvsc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second_text (
        .i_clk   (i_clk),
        .i_we    (we_second),
        .i_waddr (r_len_second[AW-1:0]),
        .i_wdata (i_byte),
        .i_raddr (i_raddr_second),
        .o_rdata (rd_second)
    );

    assign o_sts.rd_first  = rd_first;
    assign o_sts.rd_second = rd_second;
    assign o_sts.overflow  = r_overflow;
    assign o_len_first     = r_len_first;
    assign o_len_second    = r_len_second;
endmodule

// ----- sv/pvsc_ctrl.sv -----
// Sequencer: splits both strings into parts and orders them byte by byte.
module pvsc_ctrl #(
    parameter int MAX_LEN = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [1:0]                     i_in_command,
    output logic                           o_in_ready,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic signed [1:0]              o_order,
    output logic                           o_overflow,
    output pvsc_pkg::t_dp_cmd              o_dp_cmd,
    input  pvsc_pkg::t_dp_sts              i_dp_sts,
    input  logic [$clog2(MAX_LEN+1)-1:0]   i_len_first,
    input  logic [$clog2(MAX_LEN+1)-1:0]   i_len_second,
    output logic [$clog2(MAX_LEN)-1:0]     o_raddr_first,
    output logic [$clog2(MAX_LEN)-1:0]     o_raddr_second
);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int WB = 8 * pvsc_pkg::WORD_MAX;

    pvsc_pkg::t_state r_state, n_state;
    logic             r_sel, n_sel;
    logic             r_initial, n_initial;
    logic [LW-1:0]    r_pos [2], n_pos [2];
    logic [LW-1:0]    r_ps [2], n_ps [2];
    logic [LW-1:0]    r_pe [2], n_pe [2];
    logic [LW-1:0]    r_lend [2], n_lend [2];
    pvsc_pkg::t_part  r_cls [2], n_cls [2];
    logic [3:0]       r_rank [2], n_rank [2];
    logic             r_z0 [2], n_z0 [2];
    logic             r_fz [2], n_fz [2];
    pvsc_pkg::t_part  r_c, n_c;
    logic [LW-1:0]    r_q, n_q;
    logic [LW-1:0]    r_p, n_p;
    logic [LW-1:0]    r_i, n_i;
    pvsc_pkg::t_scan  r_scan, n_scan;
    logic [WB-1:0]    r_wbuf, n_wbuf;
    logic [2:0]       r_wlen, n_wlen;
    logic             r_out_valid, n_out_valid;
    pvsc_pkg::t_order r_order, n_order;
    logic             r_out_ovf, n_out_ovf;

    logic [AW-1:0]    w_raddr [2];
    logic             accept, finish, part_done, next_part, zero_next;
    pvsc_pkg::t_order res, res_final;
    logic [7:0]       d_sel;
    logic [LW-1:0]    len_sel, pos_sel, lead_q, q_next, pp, i_nx, n1, n2, m;
    logic [LW-1:0]    addr_first_nx, addr_second_nx;
    pvsc_pkg::t_part  lead_cls, c1, c2;
    logic             lead_digit_first, scan_pred;

    // Values of the selected string and common sums.
    assign d_sel            = r_sel ? i_dp_sts.rd_second : i_dp_sts.rd_first;
    assign len_sel          = r_sel ? i_len_second : i_len_first;
    assign pos_sel          = r_pos[r_sel];
    assign lead_digit_first = r_initial && pvsc_pkg::is_digit(d_sel);
    assign lead_cls         = lead_digit_first ? pvsc_pkg::PART_DOT
                                               : pvsc_pkg::lead_class(d_sel);
    assign lead_q           = lead_digit_first ? pos_sel : pos_sel + LW'(1);
    assign q_next           = r_q + LW'(1);
    assign i_nx             = r_i + LW'(1);
    assign n1               = r_pe[0] - r_ps[0];
    assign n2               = r_pe[1] - r_ps[1];
    assign m                = (n1 < n2) ? n1 : n2;
    assign addr_first_nx    = r_ps[0] + i_nx;
    assign addr_second_nx   = r_ps[1] + i_nx;
    assign c1               = r_cls[0];
    assign c2               = r_cls[1];
    assign accept           = i_in_valid && o_in_ready;

    // Character test of the run being scanned.
    always_comb begin
        case (r_scan)
            pvsc_pkg::SCAN_LOWER: scan_pred = pvsc_pkg::is_lower(d_sel);
            pvsc_pkg::SCAN_DIGIT: scan_pred = pvsc_pkg::is_digit(d_sel);
            pvsc_pkg::SCAN_HEX:   scan_pred = pvsc_pkg::is_hex(d_sel);
            default:              scan_pred = 1'b0;
        endcase
        pp = scan_pred ? r_p + LW'(1) : r_p;
    end

    // Order when the parts differ in class, or one side has run out.
    always_comb begin
        if (c1 == c2) begin
            res_final = pvsc_pkg::ORD_SAME;
        end else if ((r_fz[0] && c1 == pvsc_pkg::PART_END)
                     || (r_fz[1] && c2 == pvsc_pkg::PART_END)) begin
            res_final = pvsc_pkg::ORD_SAME;
        end else if (c1 == pvsc_pkg::PART_SUFFIX && r_rank[0] != 4'd0
                     && r_rank[0] <= pvsc_pkg::RANK_RELEASE_LAST) begin
            res_final = pvsc_pkg::ORD_OLDER;
        end else if (c2 == pvsc_pkg::PART_SUFFIX && r_rank[1] != 4'd0
                     && r_rank[1] <= pvsc_pkg::RANK_RELEASE_LAST) begin
            res_final = pvsc_pkg::ORD_NEWER;
        end else if (c1 == pvsc_pkg::PART_DOT || c2 == pvsc_pkg::PART_BAD) begin
            res_final = pvsc_pkg::ORD_NEWER;
        end else if (c2 == pvsc_pkg::PART_DOT || c1 == pvsc_pkg::PART_BAD
                     || c1 == pvsc_pkg::PART_END) begin
            res_final = pvsc_pkg::ORD_OLDER;
        end else if (c2 == pvsc_pkg::PART_END) begin
            res_final = pvsc_pkg::ORD_NEWER;
        end else if (c1 > c2) begin
            res_final = pvsc_pkg::ORD_OLDER;
        end else begin
            res_final = pvsc_pkg::ORD_NEWER;
        end
    end

    // Next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_initial   = r_initial;
        n_pos       = r_pos;
        n_ps        = r_ps;
        n_pe        = r_pe;
        n_lend      = r_lend;
        n_cls       = r_cls;
        n_rank      = r_rank;
        n_z0        = r_z0;
        n_fz        = r_fz;
        n_c         = r_c;
        n_q         = r_q;
        n_p         = r_p;
        n_i         = r_i;
        n_scan      = r_scan;
        n_wbuf      = r_wbuf;
        n_wlen      = r_wlen;
        n_out_valid = r_out_valid;
        n_order     = r_order;
        n_out_ovf   = r_out_ovf;
        w_raddr[0]  = '0;
        w_raddr[1]  = '0;
        o_dp_cmd    = '0;
        finish      = 1'b0;
        part_done   = 1'b0;
        next_part   = 1'b0;
        zero_next   = 1'b0;
        res         = pvsc_pkg::ORD_SAME;

        case (r_state)
            pvsc_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_in_command)
                        pvsc_pkg::CMD_APPEND_FIRST:  o_dp_cmd.wr_first = 1'b1;
                        pvsc_pkg::CMD_APPEND_SECOND: o_dp_cmd.wr_second = 1'b1;
                        pvsc_pkg::CMD_COMPARE:       n_state = pvsc_pkg::ST_FUZZY;
                        default: ;
                    endcase
                end
            end

            // A leading tilde makes a string fuzzy and is skipped.
            pvsc_pkg::ST_FUZZY: begin
                n_fz[0]   = (i_len_first != '0) && (i_dp_sts.rd_first == pvsc_pkg::CH_TILDE);
                n_fz[1]   = (i_len_second != '0) && (i_dp_sts.rd_second == pvsc_pkg::CH_TILDE);
                n_pos[0]  = n_fz[0] ? LW'(1) : '0;
                n_pos[1]  = n_fz[1] ? LW'(1) : '0;
                n_initial = 1'b1;
                n_sel     = 1'b0;
                n_state   = pvsc_pkg::ST_PART;
            end

            // Start of a part: end of string or fetch of the lead byte.
            pvsc_pkg::ST_PART: begin
                if (pos_sel >= len_sel) begin
                    n_cls[r_sel] = pvsc_pkg::PART_END;
                    n_ps[r_sel]  = pos_sel;
                    n_pe[r_sel]  = pos_sel;
                    part_done    = 1'b1;
                end else begin
                    w_raddr[r_sel] = pos_sel[AW-1:0];
                    n_state        = pvsc_pkg::ST_LEAD;
                end
            end

            // Lead byte: a letter part, or a separator that names the class.
            pvsc_pkg::ST_LEAD: begin
                if (pvsc_pkg::is_lower(d_sel)) begin
                    n_cls[r_sel] = pvsc_pkg::PART_LETTER;
                    n_ps[r_sel]  = pos_sel;
                    n_pe[r_sel]  = pos_sel + LW'(1);
                    part_done    = 1'b1;
                end else if (lead_q >= len_sel) begin
                    n_cls[r_sel] = pvsc_pkg::PART_BAD;
                    n_ps[r_sel]  = pos_sel;
                    n_pe[r_sel]  = pos_sel;
                    part_done    = 1'b1;
                end else begin
                    n_c            = lead_cls;
                    n_q            = lead_q;
                    n_ps[r_sel]    = lead_q;
                    w_raddr[r_sel] = lead_q[AW-1:0];
                    n_state        = pvsc_pkg::ST_BODY;
                end
            end

            // First byte after the separator decides the run to scan.
            pvsc_pkg::ST_BODY: begin
                if (r_c == pvsc_pkg::PART_DOT && pvsc_pkg::is_digit(d_sel)) begin
                    n_z0[r_sel]    = (d_sel == pvsc_pkg::CH_ZERO);
                    n_p            = r_q;
                    n_scan         = pvsc_pkg::SCAN_DIGIT;
                    w_raddr[r_sel] = r_q[AW-1:0];
                    n_state        = pvsc_pkg::ST_SCAN;
                end else if (r_c == pvsc_pkg::PART_SUFFIX && pvsc_pkg::is_lower(d_sel)) begin
                    n_p            = r_q;
                    n_scan         = pvsc_pkg::SCAN_LOWER;
                    n_wbuf         = '0;
                    n_wlen         = '0;
                    w_raddr[r_sel] = r_q[AW-1:0];
                    n_state        = pvsc_pkg::ST_SCAN;
                end else if (r_c == pvsc_pkg::PART_REV && d_sel == pvsc_pkg::CH_LOWR
                             && q_next < len_sel) begin
                    w_raddr[r_sel] = q_next[AW-1:0];
                    n_state        = pvsc_pkg::ST_REVDIG;
                end else if (r_c == pvsc_pkg::PART_HASH && pvsc_pkg::is_hex(d_sel)) begin
                    n_p            = r_q;
                    n_scan         = pvsc_pkg::SCAN_HEX;
                    w_raddr[r_sel] = r_q[AW-1:0];
                    n_state        = pvsc_pkg::ST_SCAN;
                end else begin
                    n_cls[r_sel] = pvsc_pkg::PART_BAD;
                    n_ps[r_sel]  = pos_sel;
                    n_pe[r_sel]  = pos_sel;
                    part_done    = 1'b1;
                end
            end

            // A revision needs a digit right after the 'r'.
            pvsc_pkg::ST_REVDIG: begin
                if (pvsc_pkg::is_digit(d_sel)) begin
                    n_p            = q_next;
                    n_scan         = pvsc_pkg::SCAN_DIGIT;
                    w_raddr[r_sel] = q_next[AW-1:0];
                    n_state        = pvsc_pkg::ST_SCAN;
                end else begin
                    n_cls[r_sel] = pvsc_pkg::PART_BAD;
                    n_ps[r_sel]  = pos_sel;
                    n_pe[r_sel]  = pos_sel;
                    part_done    = 1'b1;
                end
            end

            // One byte of a run per cycle; suffix letters feed the word buffer.
            pvsc_pkg::ST_SCAN: begin
                if (scan_pred && r_scan == pvsc_pkg::SCAN_LOWER) begin
                    if (r_wlen < 3'(pvsc_pkg::WORD_MAX)) begin
                        n_wbuf = {r_wbuf[WB-9:0], d_sel};
                    end
                    if (r_wlen < pvsc_pkg::WLEN_SAT) begin
                        n_wlen = r_wlen + 3'd1;
                    end
                end
                if (scan_pred && pp < len_sel) begin
                    n_p            = pp;
                    w_raddr[r_sel] = pp[AW-1:0];
                end else if (r_scan == pvsc_pkg::SCAN_LOWER) begin
                    n_lend[r_sel] = pp;
                    n_rank[r_sel] = pvsc_pkg::word_rank(n_wbuf, n_wlen);
                    if (pp < len_sel) begin
                        n_scan         = pvsc_pkg::SCAN_DIGIT;
                        n_p            = pp;
                        w_raddr[r_sel] = pp[AW-1:0];
                    end else begin
                        n_cls[r_sel] = r_c;
                        n_pe[r_sel]  = pp;
                        part_done    = 1'b1;
                    end
                end else begin
                    n_cls[r_sel] = r_c;
                    n_pe[r_sel]  = pp;
                    part_done    = 1'b1;
                end
            end

            // Both parts known: stop on a class mismatch, else test for equal text.
            pvsc_pkg::ST_EVAL: begin
                if (c1 != c2 || c1 == pvsc_pkg::PART_BAD || c1 == pvsc_pkg::PART_END) begin
                    res    = res_final;
                    finish = 1'b1;
                end else begin
                    n_pos[0] = r_pe[0];
                    n_pos[1] = r_pe[1];
                    if (n1 == n2) begin
                        if (n1 == '0) begin
                            next_part = 1'b1;
                        end else begin
                            n_i        = '0;
                            w_raddr[0] = r_ps[0][AW-1:0];
                            w_raddr[1] = r_ps[1][AW-1:0];
                            n_state    = pvsc_pkg::ST_SAME;
                        end
                    end else begin
                        n_state = pvsc_pkg::ST_DIFF;
                    end
                end
            end

            pvsc_pkg::ST_SAME: begin
                if (i_dp_sts.rd_first != i_dp_sts.rd_second) begin
                    n_state = pvsc_pkg::ST_DIFF;
                end else begin
                    n_i = i_nx;
                    if (i_nx == n1) begin
                        next_part = 1'b1;
                    end else begin
                        w_raddr[0] = addr_first_nx[AW-1:0];
                        w_raddr[1] = addr_second_nx[AW-1:0];
                    end
                end
            end

            // Parts differ: order by suffix rank, or pick numeric or byte-wise ordering.
            pvsc_pkg::ST_DIFF: begin
                case (c1)
                    pvsc_pkg::PART_REV: begin
                        n_ps[0] = r_ps[0] + LW'(1);
                        n_ps[1] = r_ps[1] + LW'(1);
                        n_sel   = 1'b0;
                        n_state = pvsc_pkg::ST_ZERO;
                    end
                    pvsc_pkg::PART_SUFFIX: begin
                        if (r_rank[0] != r_rank[1]) begin
                            res    = (r_rank[0] < r_rank[1]) ? pvsc_pkg::ORD_OLDER
                                                             : pvsc_pkg::ORD_NEWER;
                            finish = 1'b1;
                        end else begin
                            n_ps[0] = r_lend[0];
                            n_ps[1] = r_lend[1];
                            n_sel   = 1'b0;
                            n_state = pvsc_pkg::ST_ZERO;
                        end
                    end
                    pvsc_pkg::PART_DOT: begin
                        if (r_initial || (!r_z0[0] && !r_z0[1])) begin
                            n_sel   = 1'b0;
                            n_state = pvsc_pkg::ST_ZERO;
                        end else begin
                            n_state = pvsc_pkg::ST_LEX_START;
                        end
                    end
                    default: n_state = pvsc_pkg::ST_LEX_START;
                endcase
            end

            // Leading zeros are skipped, first string then second.
            pvsc_pkg::ST_ZERO: begin
                if (r_ps[r_sel] < r_pe[r_sel]) begin
                    w_raddr[r_sel] = r_ps[r_sel][AW-1:0];
                    n_state        = pvsc_pkg::ST_ZERO_CHK;
                end else begin
                    zero_next = 1'b1;
                end
            end

            pvsc_pkg::ST_ZERO_CHK: begin
                if (d_sel == pvsc_pkg::CH_ZERO) begin
                    n_ps[r_sel] = r_ps[r_sel] + LW'(1);
                    n_state     = pvsc_pkg::ST_ZERO;
                end else begin
                    zero_next = 1'b1;
                end
            end

            // More significant digits win.
            pvsc_pkg::ST_NUM: begin
                if (n1 != n2) begin
                    res    = (n1 < n2) ? pvsc_pkg::ORD_OLDER : pvsc_pkg::ORD_NEWER;
                    finish = 1'b1;
                end else begin
                    n_state = pvsc_pkg::ST_LEX_START;
                end
            end

            pvsc_pkg::ST_LEX_START: begin
                n_i = '0;
                if (m == '0) begin
                    n_state = pvsc_pkg::ST_LEN;
                end else begin
                    w_raddr[0] = r_ps[0][AW-1:0];
                    w_raddr[1] = r_ps[1][AW-1:0];
                    n_state    = pvsc_pkg::ST_LEX;
                end
            end

            // Byte-wise compare over the common length.
            pvsc_pkg::ST_LEX: begin
                if (i_dp_sts.rd_first != i_dp_sts.rd_second) begin
                    res    = (i_dp_sts.rd_first < i_dp_sts.rd_second) ? pvsc_pkg::ORD_OLDER
                                                                      : pvsc_pkg::ORD_NEWER;
                    finish = 1'b1;
                end else begin
                    n_i = i_nx;
                    if (i_nx == m) begin
                        n_state = pvsc_pkg::ST_LEN;
                    end else begin
                        w_raddr[0] = addr_first_nx[AW-1:0];
                        w_raddr[1] = addr_second_nx[AW-1:0];
                    end
                end
            end

            // A shorter prefix is older.
            pvsc_pkg::ST_LEN: begin
                if (n1 != n2) begin
                    res    = (n1 < n2) ? pvsc_pkg::ORD_OLDER : pvsc_pkg::ORD_NEWER;
                    finish = 1'b1;
                end else begin
                    next_part = 1'b1;
                end
            end

            default: n_state = pvsc_pkg::ST_IDLE;
        endcase

        // Sequencing shared by several states.
        if (part_done) begin
            if (!r_sel) begin
                n_sel   = 1'b1;
                n_state = pvsc_pkg::ST_PART;
            end else begin
                n_state = pvsc_pkg::ST_EVAL;
            end
        end
        if (zero_next) begin
            if (!r_sel) begin
                n_sel   = 1'b1;
                n_state = pvsc_pkg::ST_ZERO;
            end else begin
                n_state = pvsc_pkg::ST_NUM;
            end
        end
        if (next_part) begin
            n_initial = 1'b0;
            n_sel     = 1'b0;
            n_state   = pvsc_pkg::ST_PART;
        end

        // Result register: load on finish, free on a taken beat.
        if (finish) begin
            n_out_valid    = 1'b1;
            n_order        = res;
            n_out_ovf      = i_dp_sts.overflow;
            o_dp_cmd.clear = 1'b1;
            n_state        = pvsc_pkg::ST_IDLE;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pvsc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_sel     <= n_sel;
        r_initial <= n_initial;
        r_pos     <= n_pos;
        r_ps      <= n_ps;
        r_pe      <= n_pe;
        r_lend    <= n_lend;
        r_cls     <= n_cls;
        r_rank    <= n_rank;
        r_z0      <= n_z0;
        r_fz      <= n_fz;
        r_c       <= n_c;
        r_q       <= n_q;
        r_p       <= n_p;
        r_i       <= n_i;
        r_scan    <= n_scan;
        r_wbuf    <= n_wbuf;
        r_wlen    <= n_wlen;
        r_order   <= n_order;
        r_out_ovf <= n_out_ovf;
    end

    assign o_in_ready     = (r_state == pvsc_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid    = r_out_valid;
    assign o_order        = r_order;
    assign o_overflow     = r_out_ovf;
    assign o_raddr_first  = w_raddr[0];
    assign o_raddr_second = w_raddr[1];
endmodule
